// File: src/lrtp_pkg.sv
// lrtp_pkg: shared types and constants of the lr table parser engine
// opcodes, status codes, register indexes, parameter defaults, sequencer states
// no dependencies
package lrtp_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PROD_COUNT_DEF  = 512;
  localparam int STEP_LIMIT      = 65536;
  localparam int STEP_W          = 18;

  localparam logic [2:0] OP_TOKEN     = 3'd0;
  localparam logic [2:0] OP_WR_CHECK  = 3'd1;
  localparam logic [2:0] OP_WR_ACTION = 3'd2;
  localparam logic [2:0] OP_WR_PLEN   = 3'd3;
  localparam logic [2:0] OP_WR_PLHS   = 3'd4;
  localparam logic [2:0] OP_START     = 3'd5;

  localparam logic [2:0] ST_NEED_TOKEN = 3'd0;
  localparam logic [2:0] ST_ACCEPTED   = 3'd1;
  localparam logic [2:0] ST_ABORT_REC  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
  localparam logic [2:0] ST_MISSING_NT = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;
  localparam logic [2:0] ST_IDLE       = 3'd6;

  localparam logic [2:0] REG_START_STATE   = 3'd0;
  localparam logic [2:0] REG_SHIFT_LIMIT   = 3'd1;
  localparam logic [2:0] REG_STOP_ACTION   = 3'd2;
  localparam logic [2:0] REG_NO_ACTION     = 3'd3;
  localparam logic [2:0] REG_EOF_TOKEN     = 3'd4;
  localparam logic [2:0] REG_ERROR_TOKEN   = 3'd5;
  localparam logic [2:0] REG_DEFAULT_TOKEN = 3'd6;
  localparam logic [2:0] REG_PARENT_TOKEN  = 3'd7;

  localparam logic [1:0] ERR_LEVEL_MAX = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_STEP, S_TOPW, S_TOKR, S_DEFR, S_ERR, S_ERRW, S_ERRR,
    S_ACT, S_PRDW, S_GTOP, S_GTOPW, S_GOTO, S_RPT, S_RPTW,
    LK_IDX, LK_RD, LK_PIDX, LK_PRD
  } state_t;

endpackage

// File: src/lr_table_parser_engine.sv
// lr_table_parser_engine: table-driven lr parser with compressed action tables
// holds the check, action, production and stack memories and the sequencer
// depends on lrtp_pkg
//
// usage
//   input channel (in_valid/in_stall) carries one opcode transaction: a table
//   write, a parse start or a token with its semantic value
//   output channel (out_valid/out_stall) returns one status transaction per
//   input transaction: status, error flag, recovery level, stack depth and
//   the state and value on top of the stack
//   cfg channel (cfg_valid/cfg_ready) writes parser registers; always ready
// sequencing
//   table writes, start, unused opcodes and ignored tokens pass through the
//   execute and report states; the result is registered in the output register
//   a token reads the stack top and runs its lookup probes, and each
//   reduction adds a production read plus its two lookups; every step is bounded by
//   one read of the single-port-read stack and table memories
//   one transaction is in work at a time; a finished result waits in the
//   output register while the next transaction is accepted
// reset
//   stack empty, recovery level 0, status idle, registers at defaults;
//   tables are not cleared
// stall
//   while out_stall holds a result, the sequencer waits before writing the
//   next result; the pending output stays stable
module lr_table_parser_engine
  import lrtp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PROD_COUNT  = PROD_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [11:0]        in_table_addr,
  input  logic signed [15:0] in_table_data,
  input  logic [9:0]         in_token,
  input  logic signed [31:0] in_token_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_syntax_error,
  output logic [1:0]         out_recovering,
  output logic [7:0]         out_stack_depth,
  output logic [11:0]        out_top_state,
  output logic signed [31:0] out_top_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int TW  = $clog2(TABLE_DEPTH);
  localparam int PW  = $clog2(PROD_COUNT);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int HW  = $clog2(TABLE_DEPTH + 2);

  // configuration registers
  logic [11:0]        start_state_r;
  logic [12:0]        shift_limit_r;
  logic [11:0]        stop_action_r;
  logic signed [15:0] no_action_r;
  logic [9:0]         eof_token_r, error_token_r, default_token_r, parent_token_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r   <= '0;
      shift_limit_r   <= 13'd1;
      stop_action_r   <= '0;
      no_action_r     <= -16'sd1;
      eof_token_r     <= 10'd0;
      error_token_r   <= 10'd1;
      default_token_r <= 10'd2;
      parent_token_r  <= 10'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_STATE:   start_state_r   <= cfg_data[11:0];
        REG_SHIFT_LIMIT:   shift_limit_r   <= cfg_data[12:0];
        REG_STOP_ACTION:   stop_action_r   <= cfg_data[11:0];
        REG_NO_ACTION:     no_action_r     <= cfg_data;
        REG_EOF_TOKEN:     eof_token_r     <= cfg_data[9:0];
        REG_ERROR_TOKEN:   error_token_r   <= cfg_data[9:0];
        REG_DEFAULT_TOKEN: default_token_r <= cfg_data[9:0];
        REG_PARENT_TOKEN:  parent_token_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // memories
  logic signed [15:0] check_mem  [TABLE_DEPTH];
  logic signed [15:0] action_mem [TABLE_DEPTH];
  logic [7:0]         plen_mem   [PROD_COUNT];
  logic signed [15:0] plhs_mem   [PROD_COUNT];
  logic signed [15:0] stk_mem    [STACK_DEPTH];
  logic signed [31:0] val_mem    [STACK_DEPTH];

  logic               chk_we, act_we, plen_we, plhs_we, stk_we, val_we;
  logic [TW-1:0]      tab_waddr, tab_raddr;
  logic [PW-1:0]      prd_waddr, prd_raddr;
  logic [AW-1:0]      stk_waddr, stk_raddr;
  logic signed [15:0] stk_wdata;
  logic signed [31:0] val_wdata;
  logic signed [15:0] chk_rd, act_rd, plhs_rd, stk_rd;
  logic [7:0]         plen_rd;
  logic signed [31:0] val_rd;
  logic signed [15:0] in_data_r;

  always_ff @(posedge clk) begin
    if (chk_we) check_mem[tab_waddr] <= in_data_r;
    if (act_we) action_mem[tab_waddr] <= in_data_r;
    chk_rd <= check_mem[tab_raddr];
    act_rd <= action_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (plen_we) plen_mem[prd_waddr] <= in_data_r[7:0];
    if (plhs_we) plhs_mem[prd_waddr] <= in_data_r;
    plen_rd <= plen_mem[prd_raddr];
    plhs_rd <= plhs_mem[prd_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (val_we) val_mem[stk_waddr] <= val_wdata;
    stk_rd <= stk_mem[stk_raddr];
    val_rd <= val_mem[stk_raddr];
  end

  // sequencer registers
  state_t             state_r, state_nxt, lk_ret_r, lk_ret_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic [2:0]         run_r, run_nxt;
  logic               syn_r, syn_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [HW-1:0]      hops_r, hops_nxt;
  logic signed [15:0] lk_k_r, lk_k_nxt, lk_t_r, lk_t_nxt, lk_res_r, lk_res_nxt;
  logic signed [15:0] top_k_r, top_k_nxt, act_r, act_nxt, lhs_r, lhs_nxt;
  logic [2:0]         in_op_r;
  logic [11:0]        in_addr_r;
  logic [9:0]         in_tok_r;
  logic signed [31:0] in_val_r;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r;
  logic               out_syn_r;
  logic [1:0]         out_lvl_r;
  logic [7:0]         out_depth_r;
  logic [11:0]        out_state_r;
  logic signed [31:0] out_value_r;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      lvl_r       <= '0;
      run_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      lvl_r       <= lvl_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    syn_r    <= syn_nxt;
    steps_r  <= steps_nxt;
    hops_r   <= hops_nxt;
    lk_k_r   <= lk_k_nxt;
    lk_t_r   <= lk_t_nxt;
    lk_res_r <= lk_res_nxt;
    lk_ret_r <= lk_ret_nxt;
    top_k_r  <= top_k_nxt;
    act_r    <= act_nxt;
    lhs_r    <= lhs_nxt;
    if (in_valid && !in_stall) begin
      in_op_r   <= in_opcode;
      in_addr_r <= in_table_addr;
      in_data_r <= in_table_data;
      in_tok_r  <= in_token;
      in_val_r  <= in_token_value;
    end
    if (out_load) begin
      out_status_r <= run_r;
      out_syn_r    <= syn_r;
      out_lvl_r    <= lvl_r;
      out_depth_r  <= 8'(32'(sp_r));
      out_state_r  <= (sp_r != '0) ? stk_rd[11:0] : 12'd0;
      out_value_r  <= (sp_r != '0) ? val_rd : 32'sd0;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_syntax_error = out_syn_r;
  assign out_recovering   = out_lvl_r;
  assign out_stack_depth  = out_depth_r;
  assign out_top_state    = out_state_r;
  assign out_top_value    = out_value_r;

  // lookup index arithmetic
  logic signed [17:0] idx_a, idx_p, sl_s, act_s, res_s, pnum;
  logic               ok_a, ok_p, sp_full;
  logic [31:0]        sp_top, sp_w, addr_w, pnum_w;

  always_comb begin
    idx_a   = 18'(lk_k_r) + 18'(lk_t_r);
    idx_p   = 18'(lk_k_r) + $signed({8'd0, parent_token_r});
    sl_s    = $signed({5'd0, shift_limit_r});
    ok_a    = !idx_a[17] && (idx_a < sl_s) && (idx_a < $signed(18'(TABLE_DEPTH)));
    ok_p    = !idx_p[17] && (idx_p < sl_s) && (idx_p < $signed(18'(TABLE_DEPTH)));
    act_s   = 18'(act_r);
    res_s   = 18'(lk_res_r);
    pnum    = act_s - sl_s;
    pnum_w  = 32'(pnum);
    sp_w    = 32'(sp_r);
    sp_top  = sp_w - 32'd1;
    addr_w  = 32'(in_addr_r);
    sp_full = (sp_w >= 32'(STACK_DEPTH));
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    lvl_nxt       = lvl_r;
    run_nxt       = run_r;
    syn_nxt       = syn_r;
    steps_nxt     = steps_r;
    hops_nxt      = hops_r;
    lk_k_nxt      = lk_k_r;
    lk_t_nxt      = lk_t_r;
    lk_res_nxt    = lk_res_r;
    lk_ret_nxt    = lk_ret_r;
    top_k_nxt     = top_k_r;
    act_nxt       = act_r;
    lhs_nxt       = lhs_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    chk_we        = 1'b0;
    act_we        = 1'b0;
    plen_we       = 1'b0;
    plhs_we       = 1'b0;
    stk_we        = 1'b0;
    val_we        = 1'b0;
    tab_waddr     = addr_w[TW-1:0];
    prd_waddr     = addr_w[PW-1:0];
    tab_raddr     = '0;
    prd_raddr     = pnum_w[PW-1:0];
    stk_waddr     = sp_w[AW-1:0];
    stk_raddr     = sp_top[AW-1:0];
    stk_wdata     = lk_res_r;
    val_wdata     = in_val_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          syn_nxt   = 1'b0;
          steps_nxt = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RPT;
        case (in_op_r)
          OP_TOKEN: begin
            if (run_r == ST_NEED_TOKEN) state_nxt = S_STEP;
          end
          OP_WR_CHECK:  chk_we = (addr_w < 32'(TABLE_DEPTH));
          OP_WR_ACTION: act_we = (addr_w < 32'(TABLE_DEPTH));
          OP_WR_PLEN:   plen_we = (addr_w < 32'(PROD_COUNT));
          OP_WR_PLHS:   plhs_we = (addr_w < 32'(PROD_COUNT));
          OP_START: begin
            stk_we    = 1'b1;
            val_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = $signed({4'd0, start_state_r});
            val_wdata = 32'sd0;
            sp_nxt    = SPW'(1);
            lvl_nxt   = '0;
            run_nxt   = ST_NEED_TOKEN;
          end
          default: ;
        endcase
      end
      S_STEP: begin
        steps_nxt = steps_r + STEP_W'(1);
        if (32'(steps_nxt) > 32'(STEP_LIMIT)) begin
          run_nxt   = ST_OVERFLOW;
          state_nxt = S_RPT;
        end else if (sp_r == '0) begin
          run_nxt   = ST_UNDERFLOW;
          state_nxt = S_RPT;
        end else begin
          state_nxt = S_TOPW;
        end
      end
      S_TOPW: begin
        top_k_nxt  = stk_rd;
        lk_k_nxt   = stk_rd;
        lk_t_nxt   = $signed({6'd0, in_tok_r});
        hops_nxt   = '0;
        lk_ret_nxt = S_TOKR;
        state_nxt  = LK_IDX;
      end
      S_TOKR: begin
        if (lk_res_r != no_action_r) begin
          act_nxt   = lk_res_r;
          state_nxt = S_ACT;
        end else begin
          lk_k_nxt   = top_k_r;
          lk_t_nxt   = $signed({6'd0, default_token_r});
          hops_nxt   = '0;
          lk_ret_nxt = S_DEFR;
          state_nxt  = LK_IDX;
        end
      end
      S_DEFR: begin
        if (lk_res_r != no_action_r) begin
          act_nxt   = lk_res_r;
          state_nxt = S_ACT;
        end else if (lvl_r == ERR_LEVEL_MAX) begin
          if (in_tok_r == eof_token_r) run_nxt = ST_ABORT_REC;
          state_nxt = S_RPT;
        end else begin
          if (lvl_r == 2'd0) syn_nxt = 1'b1;
          lvl_nxt   = ERR_LEVEL_MAX;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        if (sp_r == '0) begin
          run_nxt   = ST_ABORT_REC;
          state_nxt = S_RPT;
        end else begin
          state_nxt = S_ERRW;
        end
      end
      S_ERRW: begin
        lk_k_nxt   = stk_rd;
        lk_t_nxt   = $signed({6'd0, error_token_r});
        hops_nxt   = '0;
        lk_ret_nxt = S_ERRR;
        state_nxt  = LK_IDX;
      end
      S_ERRR: begin
        if (lk_res_r != no_action_r && res_s < sl_s) begin
          if (sp_full) begin
            run_nxt   = ST_OVERFLOW;
            state_nxt = S_RPT;
          end else begin
            stk_we    = 1'b1;
            sp_nxt    = sp_r + SPW'(1);
            state_nxt = S_STEP;
          end
        end else begin
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = S_ERR;
        end
      end
      S_ACT: begin
        if (act_s < sl_s) begin
          state_nxt = S_RPT;
          if (act_s == $signed({6'd0, stop_action_r})) begin
            run_nxt = ST_ACCEPTED;
          end else if (sp_full) begin
            run_nxt = ST_OVERFLOW;
          end else begin
            stk_we    = 1'b1;
            val_we    = 1'b1;
            stk_wdata = act_r;
            sp_nxt    = sp_r + SPW'(1);
            if (lvl_r != 2'd0) lvl_nxt = lvl_r - 2'd1;
          end
        end else if (pnum_w >= 32'(PROD_COUNT)) begin
          run_nxt   = ST_MISSING_NT;
          state_nxt = S_RPT;
        end else begin
          state_nxt = S_PRDW;
        end
      end
      S_PRDW: begin
        if (32'(plen_rd) >= sp_w) begin
          sp_nxt    = '0;
          run_nxt   = ST_UNDERFLOW;
          state_nxt = S_RPT;
        end else begin
          sp_nxt    = sp_r - SPW'(plen_rd);
          lhs_nxt   = plhs_rd;
          state_nxt = S_GTOP;
        end
      end
      S_GTOP: begin
        state_nxt = S_GTOPW;
      end
      S_GTOPW: begin
        lk_k_nxt   = stk_rd;
        lk_t_nxt   = lhs_r;
        hops_nxt   = '0;
        lk_ret_nxt = S_GOTO;
        state_nxt  = LK_IDX;
      end
      S_GOTO: begin
        if (lk_res_r == no_action_r) begin
          run_nxt   = ST_MISSING_NT;
          state_nxt = S_RPT;
        end else if (sp_full) begin
          run_nxt   = ST_OVERFLOW;
          state_nxt = S_RPT;
        end else begin
          stk_we    = 1'b1;
          sp_nxt    = sp_r + SPW'(1);
          state_nxt = S_STEP;
        end
      end
      LK_IDX: begin
        tab_raddr = idx_a[TW-1:0];
        state_nxt = ok_a ? LK_RD : LK_PIDX;
      end
      LK_RD: begin
        if (chk_rd == lk_t_r) begin
          lk_res_nxt = act_rd;
          state_nxt  = lk_ret_r;
        end else begin
          state_nxt = LK_PIDX;
        end
      end
      LK_PIDX: begin
        tab_raddr = idx_p[TW-1:0];
        if (ok_p) begin
          state_nxt = LK_PRD;
        end else begin
          lk_res_nxt = no_action_r;
          state_nxt  = lk_ret_r;
        end
      end
      LK_PRD: begin
        hops_nxt = hops_r + HW'(1);
        if (chk_rd != $signed({6'd0, parent_token_r}) ||
            32'(hops_nxt) > 32'(TABLE_DEPTH)) begin
          lk_res_nxt = no_action_r;
          state_nxt  = lk_ret_r;
        end else begin
          lk_k_nxt  = act_rd;
          state_nxt = LK_IDX;
        end
      end
      S_RPT: begin
        state_nxt = S_RPTW;
      end
      S_RPTW: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
